/* src/pf_pkg.sv */
// pf_pkg: shared types and constants of the prime factorizer
// no dependencies

package pf_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int FIELD_W         = 32;
    localparam int EXP_W           = 5;
    localparam int MAX_RESULTS     = 10;
    localparam int CNT_W           = $clog2(MAX_RESULTS + 1);
    localparam int FIRST_CAND      = 2;
    localparam int CAND_STEP       = 2;

    typedef logic [EXP_W-1:0] t_exp;
    typedef logic [CNT_W-1:0] t_cnt;

    localparam t_exp EXP_MAX = '1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ,
        ST_CHK,
        ST_DIV,
        ST_EMIT
    } t_state;

endpackage

/* src/pf_divider.sv */
// pf_divider: iterative restoring divider, one quotient bit per cycle
// standalone; used by prime_factorizer_core

module pf_divider #(
    parameter int WIDTH = pf_pkg::VALUE_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WIDTH-1:0] i_dividend,
    input  logic [WIDTH-1:0] i_divisor,
    output logic             o_done,
    output logic [WIDTH-1:0] o_quot,
    output logic [WIDTH-1:0] o_rem
);

    localparam int CW = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] r_q;
    logic [WIDTH-1:0] r_r;
    logic [WIDTH-1:0] r_d;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [WIDTH:0]   w_shift;
    logic [WIDTH:0]   w_diff;

    assign w_shift = {r_r, r_q[WIDTH-1]};
    assign w_diff  = w_shift - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CW'(WIDTH);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - CW'(1);
            r_busy <= (r_cnt != CW'(1));
            r_done <= (r_cnt == CW'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_dividend;
            r_r <= '0;
            r_d <= i_divisor;
        end else if (r_busy) begin
            r_r <= w_diff[WIDTH] ? w_shift[WIDTH-1:0] : w_diff[WIDTH-1:0];
            r_q <= {r_q[WIDTH-2:0], ~w_diff[WIDTH]};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_r;

endmodule

/* src/prime_factorizer_core.sv */
// prime_factorizer_core: trial-division prime factorization, top level
// depends on pf_pkg and pf_divider
//
// input channel: i_valid / o_stall carry one item, i_value, the number to factor
// output channel: o_valid / i_stall carry one item per prime factor, in rising
// order: o_prime_factor, o_exponent and o_last on the final item of a number
// a number below 2 gives one item with factor 0, exponent 0 and o_last set
// o_stall is high from the accepted item until its last result is taken
// candidates are 2 and then every odd number while candidate squared <= rest
// each candidate costs one squaring step, one check step and one divide of
// W bits in the shared divider, W being VALUE_WIDTH capped at 32,
// plus one more divide each time the candidate divides the rest
// one item is worked at a time; the shared divider sets the rate
// while the receiver stalls, the pending result holds and work stops
// reset is synchronous and returns the block to idle, dropping any item

module prime_factorizer_core #(
    parameter int VALUE_WIDTH = pf_pkg::VALUE_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [pf_pkg::FIELD_W-1:0]  i_value,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [pf_pkg::FIELD_W-1:0]  o_prime_factor,
    output logic [pf_pkg::EXP_W-1:0]    o_exponent,
    output logic                        o_last
);

    localparam int RW = (VALUE_WIDTH < pf_pkg::FIELD_W) ? VALUE_WIDTH : pf_pkg::FIELD_W;

    pf_pkg::t_state r_state;
    pf_pkg::t_state n_state;

    logic [RW-1:0]     r_rem;
    logic [RW-1:0]     r_cand;
    logic [2*RW-1:0]   r_sq;
    pf_pkg::t_exp      r_exp;
    pf_pkg::t_cnt      r_cnt;
    logic              r_has;
    logic [RW-1:0]     r_pf;
    pf_pkg::t_exp      r_pe;
    logic              r_last;
    logic              r_done;

    logic              w_accept;
    logic              w_small;
    logic              w_sq_le;
    logic              w_more;
    logic              w_cnt_ok;
    logic              w_cnt1_ok;
    logic              w_cont;
    logic              w_end_pend;
    logic              w_final;
    logic              w_div_start;
    logic              w_div_done;
    logic              w_div_zero;
    logic [RW-1:0]     w_div_a;
    logic [RW-1:0]     w_quot;
    logic [RW-1:0]     w_drem;

    assign w_accept   = i_valid && (r_state == pf_pkg::ST_IDLE);
    assign w_small    = (i_value[RW-1:0] < RW'(2));
    assign w_sq_le    = (r_sq <= (2*RW)'(r_rem));
    assign w_more     = (r_rem > RW'(1));
    assign w_cnt_ok   = (r_cnt < pf_pkg::CNT_W'(pf_pkg::MAX_RESULTS));
    assign w_cnt1_ok  = ((r_cnt + pf_pkg::CNT_W'(1)) < pf_pkg::CNT_W'(pf_pkg::MAX_RESULTS));
    assign w_cont     = w_sq_le && w_cnt_ok;
    assign w_end_pend = !(w_sq_le && w_cnt1_ok) && !(w_more && w_cnt1_ok);
    assign w_final    = w_more && w_cnt_ok;
    assign w_div_zero = (w_drem == '0);
    assign w_div_a    = (r_state == pf_pkg::ST_DIV) ? w_quot : r_rem;

    pf_divider #(
        .WIDTH (RW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_a),
        .i_divisor  (r_cand),
        .o_done     (w_div_done),
        .o_quot     (w_quot),
        .o_rem      (w_drem)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pf_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = w_small ? pf_pkg::ST_EMIT : pf_pkg::ST_SQ;
                end
            end
            pf_pkg::ST_SQ: begin
                n_state = pf_pkg::ST_CHK;
            end
            pf_pkg::ST_CHK: begin
                if (r_has || (!w_cont && w_final)) begin
                    n_state = pf_pkg::ST_EMIT;
                end else if (w_cont) begin
                    n_state = pf_pkg::ST_DIV;
                end else begin
                    n_state = pf_pkg::ST_IDLE;
                end
            end
            pf_pkg::ST_DIV: begin
                if (w_div_done && !w_div_zero) begin
                    n_state = pf_pkg::ST_SQ;
                end
            end
            pf_pkg::ST_EMIT: begin
                if (!i_stall) begin
                    n_state = r_done ? pf_pkg::ST_IDLE : pf_pkg::ST_CHK;
                end
            end
            default: n_state = pf_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        w_div_start = 1'b0;
        o_stall     = 1'b1;
        o_valid     = 1'b0;
        unique case (r_state)
            pf_pkg::ST_IDLE: o_stall     = 1'b0;
            pf_pkg::ST_CHK:  w_div_start = !r_has && w_cont;
            pf_pkg::ST_DIV:  w_div_start = w_div_done && w_div_zero;
            pf_pkg::ST_EMIT: o_valid     = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pf_pkg::ST_IDLE;
            r_has   <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                pf_pkg::ST_IDLE: r_has <= 1'b0;
                pf_pkg::ST_DIV:  begin
                    if (w_div_done && !w_div_zero) begin
                        r_has <= (r_exp != '0);
                    end
                end
                pf_pkg::ST_EMIT: begin
                    if (!i_stall) begin
                        r_has <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            pf_pkg::ST_IDLE: begin
                if (w_accept) begin
                    r_rem  <= i_value[RW-1:0];
                    r_cand <= RW'(pf_pkg::FIRST_CAND);
                    r_exp  <= '0;
                    r_cnt  <= '0;
                    r_pf   <= '0;
                    r_pe   <= '0;
                    r_last <= 1'b1;
                    r_done <= 1'b1;
                end
            end
            pf_pkg::ST_SQ: begin
                r_sq <= (2*RW)'(r_cand) * (2*RW)'(r_cand);
            end
            pf_pkg::ST_CHK: begin
                if (r_has) begin
                    r_last <= w_end_pend;
                    r_done <= w_end_pend;
                end else if (!w_cont && w_final) begin
                    r_pf   <= r_rem;
                    r_pe   <= pf_pkg::t_exp'(1);
                    r_last <= 1'b1;
                    r_done <= 1'b1;
                end
            end
            pf_pkg::ST_DIV: begin
                if (w_div_done) begin
                    if (w_div_zero) begin
                        r_rem <= w_quot;
                        if (r_exp != pf_pkg::EXP_MAX) begin
                            r_exp <= r_exp + pf_pkg::t_exp'(1);
                        end
                    end else begin
                        r_pf  <= r_cand;
                        r_pe  <= r_exp;
                        r_exp <= '0;
                        if (r_cand == RW'(pf_pkg::FIRST_CAND)) begin
                            r_cand <= RW'(pf_pkg::FIRST_CAND + 1);
                        end else begin
                            r_cand <= r_cand + RW'(pf_pkg::CAND_STEP);
                        end
                    end
                end
            end
            pf_pkg::ST_EMIT: begin
                if (!i_stall && !r_done) begin
                    r_cnt <= r_cnt + pf_pkg::CNT_W'(1);
                end
            end
            default: ;
        endcase
    end

    assign o_prime_factor = pf_pkg::FIELD_W'(r_pf);
    assign o_exponent     = r_pe;
    assign o_last         = r_last;

endmodule

/* tb/tb_prime_factorizer_core.sv */
// tb_prime_factorizer_core: self-checking testbench for the trial-division prime factorizer
// depends on pf_pkg and prime_factorizer_core; numbers go in over valid/stall, and each
// factor item is checked in order against a software factorization or a typed table row
`timescale 1ns / 1ps

module tb_prime_factorizer_core;

    localparam int NUM_DIRECTED   = 20;
    localparam int NUM_RANDOM     = 80;
    localparam int WATCHDOG_LIMIT = 500000;
    localparam int TAIL_CYCLES    = 64;

    typedef struct packed {
        logic [pf_pkg::FIELD_W-1:0] prime_factor;
        pf_pkg::t_exp               exponent;
        logic                       last;
    } t_factor;

    typedef struct packed {
        logic [pf_pkg::FIELD_W-1:0] value;
        logic                       typed;
        logic [pf_pkg::FIELD_W-1:0] prime_factor;
        pf_pkg::t_exp               exponent;
    } t_number_row;

    // typed rows give a single factor item with last set
    localparam t_number_row DIRECTED_NUMBERS [0:NUM_DIRECTED-1] = '{
        '{32'd0,          1'b1, 32'd0, 5'd0},
        '{32'd1,          1'b1, 32'd0, 5'd0},
        '{32'd2,          1'b1, 32'd2, 5'd1},
        '{32'd3,          1'b1, 32'd3, 5'd1},
        '{32'h8000_0000,  1'b1, 32'd2, 5'd31},
        '{32'd4,          1'b0, 32'd0, 5'd0},
        '{32'd9,          1'b0, 32'd0, 5'd0},
        '{32'd60,         1'b0, 32'd0, 5'd0},
        '{32'd97,         1'b0, 32'd0, 5'd0},
        '{32'd1024,       1'b0, 32'd0, 5'd0},
        '{32'd63001,      1'b0, 32'd0, 5'd0},
        '{32'd131074,     1'b0, 32'd0, 5'd0},
        '{32'd223092870,  1'b0, 32'd0, 5'd0},
        '{32'd3486784401, 1'b0, 32'd0, 5'd0},
        '{32'h4000_0000,  1'b0, 32'd0, 5'd0},
        '{32'hFFFF_0000,  1'b0, 32'd0, 5'd0},
        '{32'hFFFF_FFFF,  1'b0, 32'd0, 5'd0},
        '{32'hFFFF_FD00,  1'b0, 32'd0, 5'd0},
        '{32'hAAAA_AAAA,  1'b0, 32'd0, 5'd0},
        '{32'h5555_5555,  1'b0, 32'd0, 5'd0}
    };

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_valid;
    logic                       o_stall;
    logic [pf_pkg::FIELD_W-1:0] i_value;
    logic                       o_valid;
    logic                       i_stall;
    logic [pf_pkg::FIELD_W-1:0] o_prime_factor;
    logic [pf_pkg::EXP_W-1:0]   o_exponent;
    logic                       o_last;

    t_factor pending_factors[$];
    int      mismatches;
    int      numbers_sent;
    int      factors_checked;
    int      most_factors;
    int      idle_cycles;
    int      burst_left;
    int      stall_mode;
    int      stall_left;

    prime_factorizer_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_value        (i_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_prime_factor (o_prime_factor),
        .o_exponent     (o_exponent),
        .o_last         (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    task automatic push_factor(input t_factor item, inout bit have_held, inout t_factor held,
                               inout int run_len);
        if (have_held) begin
            pending_factors.insert(pending_factors.size(), held);
        end
        held      = item;
        have_held = 1'b1;
        run_len++;
    endtask

    task automatic compute_factors(input logic [pf_pkg::FIELD_W-1:0] value);
        logic [63:0] rest;
        logic [63:0] cand;
        int unsigned power;
        bit          have_held;
        t_factor     held;
        t_factor     item;
        int          run_len;
        rest      = {32'd0, value};
        cand      = 64'(pf_pkg::FIRST_CAND);
        have_held = 1'b0;
        held      = '0;
        run_len   = 0;
        if (rest < 2) begin
            push_factor('{prime_factor: '0, exponent: '0, last: 1'b0}, have_held, held, run_len);
        end else begin
            while (cand <= rest / cand && run_len < pf_pkg::MAX_RESULTS) begin
                power = 0;
                while (rest % cand == 0) begin
                    rest = rest / cand;
                    power++;
                end
                if (power > 0) begin
                    item.prime_factor = cand[pf_pkg::FIELD_W-1:0];
                    item.exponent     = (power > pf_pkg::EXP_MAX) ? pf_pkg::EXP_MAX :
                                        power[pf_pkg::EXP_W-1:0];
                    item.last         = 1'b0;
                    push_factor(item, have_held, held, run_len);
                end
                cand = (cand == 64'(pf_pkg::FIRST_CAND)) ? 64'd3 :
                       cand + 64'(pf_pkg::CAND_STEP);
            end
            if (rest > 1 && run_len < pf_pkg::MAX_RESULTS) begin
                push_factor('{prime_factor: rest[pf_pkg::FIELD_W-1:0],
                              exponent: pf_pkg::t_exp'(1), last: 1'b0},
                            have_held, held, run_len);
            end
        end
        held.last = 1'b1;
        pending_factors.insert(pending_factors.size(), held);
        if (run_len > most_factors) begin
            most_factors = run_len;
        end
    endtask

    task automatic send_number(input t_number_row row);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 10);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_valid <= 1'b1;
        i_value <= row.value;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (row.typed) begin
            pending_factors.insert(pending_factors.size(),
                                   t_factor'{prime_factor: row.prime_factor,
                                             exponent: row.exponent, last: 1'b1});
            if (most_factors < 1) begin
                most_factors = 1;
            end
        end else begin
            compute_factors(row.value);
        end
        numbers_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending_factors.size() != 0);
        burst_left = 0;
    endtask

    function automatic logic [pf_pkg::FIELD_W-1:0] random_number();
        logic [63:0] acc;
        logic [63:0] f;
        int          mode;
        int          n;
        int          w;
        acc  = 64'd1;
        mode = $urandom_range(0, 9);
        if (mode <= 4) begin
            n = $urandom_range(1, 12);
            repeat (n) begin
                f = 64'($urandom_range(2, 60));
                if (acc * f <= 64'hFFFF_FFFF) acc = acc * f;
            end
        end else if (mode <= 6) begin
            n = $urandom_range(0, 3);
            repeat (n) begin
                f = 64'($urandom_range(2, 30));
                acc = acc * f;
            end
            f = 64'($urandom_range(2, 1 << 18));
            if (acc * f <= 64'hFFFF_FFFF) acc = acc * f;
        end else if (mode == 7) begin
            f   = 64'($urandom_range(2, 12));
            acc = f;
            while (acc * f <= 64'hFFFF_FFFF && $urandom_range(0, 7) != 0) acc = acc * f;
        end else if (mode == 8) begin
            w   = $urandom_range(1, 20);
            acc = {32'd0, $urandom} & ((64'd1 << w) - 1);
        end else begin
            // push toward the top of the range with small factors only
            forever begin
                f = 64'($urandom_range(2, 7));
                if (acc * f > 64'hFFFF_FFFF) break;
                acc = acc * f;
            end
        end
        return acc[pf_pkg::FIELD_W-1:0];
    endfunction

    task automatic check_factor();
        t_factor want;
        if (pending_factors.size() == 0) begin
            $error("unexpected item: prime_factor %0d exponent %0d last %0b",
                   o_prime_factor, o_exponent, o_last);
            mismatches++;
        end else begin
            want = pending_factors.pop_front();
            factors_checked++;
            if (o_prime_factor !== want.prime_factor) begin
                $error("prime_factor: expected %0d, actual %0d", want.prime_factor,
                       o_prime_factor);
                mismatches++;
            end
            if (o_exponent !== want.exponent) begin
                $error("exponent: expected %0d, actual %0d", want.exponent, o_exponent);
                mismatches++;
            end
            if (o_last !== want.last) begin
                $error("last: expected %0b, actual %0b", want.last, o_last);
                mismatches++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles = 0;
        end else begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (o_valid && !i_stall) begin
                check_factor();
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no item moved for %0d cycles", idle_cycles);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // receiver stall pattern: free-running, light random, half random and heavy stall segments
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(10, 200);
        end
        stall_left--;
        case (stall_mode)
            0: begin
                i_stall <= 1'b0;
            end
            1: begin
                i_stall <= ($urandom_range(0, 3) == 0);
            end
            2: begin
                i_stall <= ($urandom_range(0, 1) == 0);
            end
            default: begin
                i_stall <= ($urandom_range(0, 9) != 0);
            end
        endcase
    end

    initial begin
        t_number_row row;
        i_rst_n         <= 1'b0;
        i_valid         <= 1'b0;
        i_value         <= '0;
        mismatches      = 0;
        numbers_sent    = 0;
        factors_checked = 0;
        most_factors    = 0;
        burst_left      = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int k = 0; k < NUM_DIRECTED; k++) begin
            send_number(DIRECTED_NUMBERS[k]);
        end
        wait_drained();

        for (int k = 0; k < NUM_RANDOM; k++) begin
            row       = '0;
            row.value = random_number();
            send_number(row);
            if (k % 25 == 24) begin
                wait_drained();
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("covered %0d numbers (%0d directed): zero, one, primes, powers, squares,",
                 numbers_sent, NUM_DIRECTED);
        $display("  values near the top of range; %0d factor items checked, up to %0d per number",
                 factors_checked, most_factors);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
